[rtl/core/spq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Field widths of the item formats.
    localparam int ELEM_W      = 32;
    localparam int PRIO_W      = 16;
    localparam int COUNT_OUT_W = 5;

    // Default number of entries.
    localparam int DEF_CAPACITY = 16;

    typedef enum logic [2:0] {
        OP_INSERT      = 3'd0,
        OP_REMOVE_HEAD = 3'd1,
        OP_REMOVE_ELEM = 3'd2,
        OP_CHANGE_PRIO = 3'd3,
        OP_CONTAINS    = 3'd4,
        OP_CLEAR       = 3'd5,
        OP_GET_FIRST   = 3'd6,
        OP_GET_NEXT    = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_MISSING = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [ELEM_W-1:0]   element;
        logic [PRIO_W-1:0]   priority_req;
        logic [PRIO_W-1:0]   priority_repl;
    } spq_in_t;

    typedef struct packed {
        status_t                status;
        logic [ELEM_W-1:0]      element_out;
        logic                   element_valid;
        logic                   found;
        logic [COUNT_OUT_W-1:0] entry_count;
    } spq_out_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_REINS = 2'd2
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // capture the incoming item
        logic exec;      // carry out the captured command
        logic reinsert;  // second half of a priority change
    } spq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_reinsert;
    } spq_stat_t;

endpackage

`default_nettype wire

[rtl/core/spq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output spq_pkg::spq_cmd_t      cmd,
    input  wire spq_pkg::spq_stat_t stat
);
    import spq_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    cmd.exec = 1'b1;
                    if (stat.need_reinsert) begin
                        state_next = S_REINS;
                    end else begin
                        m_valid_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_REINS: begin
                if (out_free) begin
                    cmd.reinsert = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Only one datapath command is issued in any cycle.
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.exec, cmd.reinsert}))
        else $error("more than one datapath command at once");

    // The reinsert step only ever follows the execute step.
    a_reins_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == S_REINS) |-> $past(state_reg) == S_EXEC)
        else $error("reinsert step entered from the wrong state");

    // Every finishing step leaves a result on the output or goes on to reinsert.
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec || cmd.reinsert) |=> (m_valid_reg || state_reg == S_REINS))
        else $error("finished command left no result");

endmodule

`default_nettype wire

[rtl/core/spq_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire spq_pkg::spq_in_t   in_item,
    input  wire spq_pkg::spq_cmd_t  cmd,
    output spq_pkg::spq_stat_t      stat,
    output spq_pkg::spq_out_t       out_item
);
    import spq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Captured command and the sorted cell array (head in cell 0).
    spq_in_t            cmd_reg;
    logic [ELEM_W-1:0]  elem_reg  [CAPACITY];
    logic [PRIO_W-1:0]  prio_reg  [CAPACITY];
    logic [ELEM_W-1:0]  elem_next [CAPACITY];
    logic [PRIO_W-1:0]  prio_next [CAPACITY];
    logic [ELEM_W-1:0]  elem_from_prev [CAPACITY];
    logic [PRIO_W-1:0]  prio_from_prev [CAPACITY];
    logic [ELEM_W-1:0]  elem_from_succ [CAPACITY];
    logic [PRIO_W-1:0]  prio_from_succ [CAPACITY];

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   cursor_reg, cursor_next;
    logic               cursor_valid_reg, cursor_valid_next;
    spq_out_t           res_reg, res_next;

    logic [CAPACITY-1:0] occupied;
    logic [CAPACITY-1:0] match_elem;
    logic [CAPACITY-1:0] match_both;
    logic [CAPACITY-1:0] ge;
    logic [CAPACITY-1:0] ge_prev;
    logic [CAPACITY-1:0] drop_vec;
    logic [PRIO_W-1:0]   ins_prio;
    logic                any_elem, any_both, full, not_empty;
    logic                do_insert, do_drop, do_clear, load_res;
    logic [IDX_W-1:0]    cursor_inc;
    logic                next_ok;

    // Marks every position at or after the first set bit, in log2 steps.
    function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] v);
        logic [CAPACITY-1:0] p;
        p = v;
        for (int s = 1; s < CAPACITY; s = s * 2) begin
            p = p | (p << s);
        end
        return p;
    endfunction

    assign ins_prio  = cmd.reinsert ? cmd_reg.priority_repl : cmd_reg.priority_req;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign not_empty = (count_reg != '0);
    assign any_elem  = |match_elem;
    assign any_both  = |match_both;
    assign ge_prev   = {ge[CAPACITY-2:0], 1'b1};

    assign stat.need_reinsert = (cmd_reg.opcode == OP_CHANGE_PRIO) && any_both;

    // Per-cell compares and neighbor taps.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign occupied[i]   = CNT_W'(i) < count_reg;
        assign match_elem[i] = occupied[i] && (elem_reg[i] == cmd_reg.element);
        assign match_both[i] = match_elem[i] && (prio_reg[i] == cmd_reg.priority_req);
        assign ge[i]         = occupied[i] && (prio_reg[i] >= ins_prio);

        if (i == 0) begin : g_first
            assign elem_from_prev[i] = cmd_reg.element;
            assign prio_from_prev[i] = ins_prio;
        end else begin : g_inner
            assign elem_from_prev[i] = elem_reg[i-1];
            assign prio_from_prev[i] = prio_reg[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign elem_from_succ[i] = elem_reg[i];
            assign prio_from_succ[i] = prio_reg[i];
        end else begin : g_body
            assign elem_from_succ[i] = elem_reg[i+1];
            assign prio_from_succ[i] = prio_reg[i+1];
        end

        // A cell below the insert point takes the new entry or its upper
        // neighbor; a cell at or after the first dropped slot takes its
        // lower neighbor.
        always_comb begin
            elem_next[i] = elem_reg[i];
            prio_next[i] = prio_reg[i];
            if (do_insert) begin
                if (!ge[i]) begin
                    if (ge_prev[i]) begin
                        elem_next[i] = cmd_reg.element;
                        prio_next[i] = ins_prio;
                    end else begin
                        elem_next[i] = elem_from_prev[i];
                        prio_next[i] = prio_from_prev[i];
                    end
                end
            end else if (do_drop && drop_vec[i]) begin
                elem_next[i] = elem_from_succ[i];
                prio_next[i] = prio_from_succ[i];
            end
        end

        always_ff @(posedge aclk) begin
            elem_reg[i] <= elem_next[i];
            prio_reg[i] <= prio_next[i];
        end
    end

    assign cursor_inc = cursor_reg + IDX_W'(1);
    assign next_ok    = cursor_valid_reg && ((CNT_W'(cursor_reg) + CNT_W'(1)) < count_reg);

    always_comb begin
        do_insert         = 1'b0;
        do_drop           = 1'b0;
        do_clear          = 1'b0;
        drop_vec          = '0;
        load_res          = 1'b0;
        cursor_next       = cursor_reg;
        cursor_valid_next = cursor_valid_reg;
        res_next          = res_reg;
        res_next.status        = STAT_OK;
        res_next.element_out   = '0;
        res_next.element_valid = 1'b0;
        res_next.found         = 1'b0;

        if (cmd.reinsert) begin
            do_insert = 1'b1;
            load_res  = 1'b1;
        end else if (cmd.exec) begin
            load_res = 1'b1;
            case (cmd_reg.opcode)
                OP_INSERT: begin
                    do_insert         = !full;
                    cursor_valid_next = 1'b0;
                    if (full) begin
                        res_next.status = STAT_FULL;
                    end
                end
                OP_REMOVE_HEAD: begin
                    drop_vec          = '1;
                    do_drop           = not_empty;
                    cursor_valid_next = 1'b0;
                end
                OP_REMOVE_ELEM: begin
                    drop_vec = prefix_or(match_elem);
                    do_drop  = any_elem;
                    if (any_elem) begin
                        cursor_valid_next = 1'b0;
                    end else begin
                        res_next.status = STAT_MISSING;
                    end
                end
                OP_CHANGE_PRIO: begin
                    drop_vec = prefix_or(match_both);
                    do_drop  = any_both;
                    if (any_both) begin
                        cursor_valid_next = 1'b0;
                        load_res          = 1'b0;
                    end else begin
                        res_next.status = STAT_MISSING;
                    end
                end
                OP_CONTAINS: begin
                    res_next.found = any_elem;
                end
                OP_CLEAR: begin
                    do_clear          = 1'b1;
                    cursor_valid_next = 1'b0;
                end
                OP_GET_FIRST: begin
                    if (not_empty) begin
                        cursor_next            = '0;
                        cursor_valid_next      = 1'b1;
                        res_next.element_out   = elem_reg[0];
                        res_next.element_valid = 1'b1;
                    end
                end
                OP_GET_NEXT: begin
                    if (next_ok) begin
                        cursor_next            = cursor_inc;
                        res_next.element_out   = elem_reg[cursor_inc];
                        res_next.element_valid = 1'b1;
                    end
                end
                default: begin
                    load_res = 1'b0;
                end
            endcase
        end

        if (do_clear) begin
            count_next = '0;
        end else if (do_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_drop) begin
            count_next = count_reg - CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
        res_next.entry_count = COUNT_OUT_W'(count_next);

        if (!load_res) begin
            res_next = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg <= in_item;
        end
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg        <= '0;
            cursor_reg       <= '0;
            cursor_valid_reg <= 1'b0;
        end else begin
            count_reg        <= count_next;
            cursor_reg       <= cursor_next;
            cursor_valid_reg <= cursor_valid_next;
        end
    end

    assign out_item = res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_valid_reg |-> (CNT_W'(cursor_reg) < count_reg))
        else $error("valid cursor points past the last entry");

    a_reinsert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.reinsert |-> !full)
        else $error("reinsert into a full array");

endmodule

`default_nettype wire

[rtl/core/sorted_priority_queue_unit.sv]
// An accepted item is held in the command register; the execute step then registers
// its result, or for a priority change that finds its entry, the reinsert step does.
// An output stall holds either step. The controller runs one command at a time through
// the cell array update and takes a new item only once the last result is loaded.
// Reset: aresetn is synchronous, active low; it empties the queue, drops the cursor
// and clears the output valid. Stored entries are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire spq_pkg::spq_in_t s_item,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output spq_pkg::spq_out_t     m_item
);
    import spq_pkg::*;

    // The controller sequences each item through capture, execute and, for a
    // priority change that hits, a reinsert step. The result register in the
    // datapath decouples the two channels, so a new item is taken while an
    // earlier result still waits for m_ready.
    spq_cmd_t  cmd;
    spq_stat_t stat;

    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // The datapath holds the entries as a row of cells kept in priority order.
    // Every cell compares itself against the command at once; inserts shift
    // the cells below the insert point down by one, and removals shift the
    // cells from the first match onward up by one.
    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_item),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (m_item)
    );

endmodule

`default_nettype wire
